@@ design/psfd_pkg.sv @@
// Shared types, constants and widths for the pressure sensor frame decoder.
package psfd_pkg;

    // Sensor status field, bits 7..6 of a frame start byte
    typedef enum logic [1:0] {
        SENS_NORMAL = 2'b00,
        SENS_CMD    = 2'b01,
        SENS_STALE  = 2'b10,
        SENS_DIAG   = 2'b11
    } sens_status_t;

    // Result status code
    typedef enum logic [1:0] {
        RES_VALID = 2'd0,
        RES_CMD   = 2'd1,
        RES_DIAG  = 2'd2
    } res_status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_PSTART,
        S_PWAIT,
        S_TMUL,
        S_TOFF,
        S_TSTART,
        S_TWAIT,
        S_EMIT
    } state_t;

    // Divider steps
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RECIP,
        DIV_BACK,
        DIV_FIX
    } div_step_t;

    // Config register indexes
    localparam int unsigned REG_PMIN = 0;
    localparam int unsigned REG_PMAX = 1;

    localparam int CFG_W   = 24;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Divider widths: dividend covers |(raw - 1638) * (max - min)| < 2^38
    localparam int DVD_W   = 38;
    localparam int DVS_W   = 14;
    localparam int PROD_W  = DVD_W + 1;
    localparam int QUO_W   = 25;
    // remainder after the estimate stays below three divisors
    localparam int REM_W   = 16;
    // reciprocals are floor(2^DVD_W / divisor)
    localparam int RCP_W   = 28;
    localparam int DIV_AW  = 32;

    localparam int MUL_AW  = 15;
    localparam int MUL_BW  = 25;
    localparam int MUL_PW  = MUL_AW + MUL_BW;

    localparam logic signed [MUL_AW-1:0] OUT_CNT_MIN  = 15'sd1638;
    localparam logic [DVS_W-1:0]         OUT_CNT_SPAN = 14'd13107;
    localparam logic signed [MUL_BW-1:0] TEMP_GAIN    = 25'sd20000;
    localparam logic signed [PROD_W-1:0] TEMP_OFFSET  = 39'sd10235000;
    localparam logic [DVS_W-1:0]         TEMP_SPAN    = 14'd2047;

    localparam logic [RCP_W-1:0] PRESS_RECIP = 28'd20971840;
    localparam logic [RCP_W-1:0] TEMP_RECIP  = 28'd134283296;

    localparam logic signed [26:0] PRESS_SAT_MAX = 27'sd33554431;
    localparam logic signed [26:0] PRESS_SAT_MIN = -27'sd33554432;

    localparam logic signed [CFG_W-1:0] PMIN_RESET = 24'sd0;
    localparam logic signed [CFG_W-1:0] PMAX_RESET = 24'sd100000;

endpackage

@@ design/psfd_if.sv @@
// Valid/ready channel interfaces for sensor bytes and decoded results.
interface psfd_byte_if;
    import psfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface psfd_res_if;
    import psfd_pkg::*;

    logic               valid;
    logic               ready;
    res_status_t        status_code;
    logic [13:0]        raw_pressure;
    logic [10:0]        raw_temperature;
    logic signed [25:0] pressure;
    logic signed [14:0] temperature_centi;

    modport source (output valid, output status_code, output raw_pressure,
                    output raw_temperature, output pressure, output temperature_centi,
                    input ready);
    modport sink   (input valid, input status_code, input raw_pressure,
                    input raw_temperature, input pressure, input temperature_centi,
                    output ready);
endinterface

@@ design/psfd_regs.sv @@
// APB register bank holding the configured pressure range.
module psfd_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [psfd_pkg::APB_AW-1:0]        paddr,
    input  logic [psfd_pkg::APB_DW-1:0]        pwdata,
    output logic [psfd_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    output logic signed [psfd_pkg::CFG_W-1:0]  pressure_min,
    output logic signed [psfd_pkg::CFG_W-1:0]  pressure_max
);
    import psfd_pkg::*;

    logic signed [CFG_W-1:0] pmin_reg, pmin_next;
    logic signed [CFG_W-1:0] pmax_reg, pmax_next;
    logic                    wr_en;
    logic                    reg_sel;

    // word select only, byte lanes ignored
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        pmin_next = pmin_reg;
        pmax_next = pmax_reg;
        if (wr_en)
        begin
            if (reg_sel == 1'(REG_PMAX))
                pmax_next = pwdata[CFG_W-1:0];
            else
                pmin_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg <= PMIN_RESET;
            pmax_reg <= PMAX_RESET;
        end
        else
        begin
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
        end
    end

    assign prdata = (reg_sel == 1'(REG_PMAX))
                    ? {{(APB_DW-CFG_W){1'b0}}, pmax_reg}
                    : {{(APB_DW-CFG_W){1'b0}}, pmin_reg};

    assign pressure_min = pmin_reg;
    assign pressure_max = pmax_reg;

endmodule

@@ design/psfd_div.sv @@
// Divider for the fixed spans: reciprocal estimate, back-multiply, remainder fix-up.
module psfd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psfd_pkg::DVD_W-1:0]  dividend,
    input  logic [psfd_pkg::DVS_W-1:0]  divisor,
    input  logic [psfd_pkg::RCP_W-1:0]  recip,
    output logic                        done,
    output logic [psfd_pkg::QUO_W-1:0]  quotient
);
    import psfd_pkg::*;

    div_step_t               step_reg, step_next;
    logic                    done_reg, done_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic [RCP_W-1:0]        rcp_reg, rcp_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [DIV_AW-1:0]       mul_a;
    logic [RCP_W-1:0]        mul_b;
    logic [DIV_AW+RCP_W-1:0] mul_p;
    logic [DVD_W-1:0]        rem_full;
    logic [REM_W-1:0]        dvs_x1;
    logic [REM_W-1:0]        dvs_x2;

    assign mul_p    = mul_a * mul_b;
    assign rem_full = dvd_reg - mul_p[DVD_W-1:0];
    assign dvs_x1   = REM_W'(dvs_reg);
    assign dvs_x2   = REM_W'({dvs_reg, 1'b0});

    // Next step
    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            DIV_IDLE:
            begin
                if (start)
                    step_next = DIV_RECIP;
            end
            DIV_RECIP: step_next = DIV_BACK;
            DIV_BACK:  step_next = DIV_FIX;
            DIV_FIX:   step_next = DIV_IDLE;
            default:   step_next = DIV_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rcp_next  = rcp_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        mul_a     = '0;
        mul_b     = '0;
        unique case (step_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    dvd_next = dividend;
                    dvs_next = divisor;
                    rcp_next = recip;
                end
            end
            DIV_RECIP:
            begin
                // top dividend bits times reciprocal; estimate is low by at most two
                mul_a    = dvd_reg[DVD_W-1 -: DIV_AW];
                mul_b    = rcp_reg;
                quo_next = mul_p[DIV_AW +: QUO_W];
            end
            DIV_BACK:
            begin
                mul_a    = DIV_AW'(quo_reg);
                mul_b    = RCP_W'(dvs_reg);
                rem_next = rem_full[REM_W-1:0];
            end
            DIV_FIX:
            begin
                done_next = 1'b1;
                if (rem_reg >= dvs_x2)
                    quo_next = quo_reg + QUO_W'(2);
                else if (rem_reg >= dvs_x1)
                    quo_next = quo_reg + QUO_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= DIV_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rcp_reg <= rcp_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/pressure_sensor_frame_decode_scale.sv @@
// Top level: sensor frame decoder, scaling sequencer and result register.
//
//  channel   dir  request moved                        accepted when
//  sens_in   in   rx_byte, frame_start                 valid && ready
//  res_out   out  status, raw counts, pressure, temp   valid && ready
//  apb       in   pressure_min / pressure_max write    psel && penable && pwrite
//
// Flow: header and data bytes are taken one per cycle while the sequencer is
// idle. The fourth byte of a frame holds ready low through the multiply and
// divider start for each quantity, the reciprocal divider's steps for each
// (estimate, back-multiply, fix-up, done), the temperature offset and the
// result load. An error status byte is accepted, then its result is loaded.
// Reset: asynchronous, clears sequencer, frame tracking and result valid.
// Stalls: a waiting result does not block header or data bytes; a new result
// is held in the sequencer until the output register is free.
module pressure_sensor_frame_decode_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    psfd_byte_if.sink                   sens_in,
    psfd_res_if.source                  res_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psfd_pkg::APB_AW-1:0] paddr,
    input  logic [psfd_pkg::APB_DW-1:0] pwdata,
    output logic [psfd_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import psfd_pkg::*;

    // Config
    logic signed [CFG_W-1:0] pressure_min;
    logic signed [CFG_W-1:0] pressure_max;

    // Sequencer
    state_t state_reg, state_next;

    // Frame tracking
    logic        frame_active_reg, frame_active_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [13:0] p_accum_reg, p_accum_next;
    logic [7:0]  t_high_reg, t_high_next;

    // Working registers
    logic [13:0]              raw_p_reg, raw_p_next;
    logic [10:0]              raw_t_reg, raw_t_next;
    logic                     err_reg, err_next;
    res_status_t              err_code_reg, err_code_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic signed [25:0]       press_reg, press_next;
    logic signed [14:0]       temp_reg, temp_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    res_status_t        out_status_reg, out_status_next;
    logic [13:0]        out_raw_p_reg, out_raw_p_next;
    logic [10:0]        out_raw_t_reg, out_raw_t_next;
    logic signed [25:0] out_press_reg, out_press_next;
    logic signed [14:0] out_temp_reg, out_temp_next;

    // Shared multiplier
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;

    // Shared divider
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [RCP_W-1:0] div_recip;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;

    logic                     in_acc;
    logic                     slot_free;
    sens_status_t             sens_st;
    logic signed [PROD_W-1:0] prod_neg;
    logic signed [25:0]       pq;
    logic signed [26:0]       p_sum;
    logic signed [14:0]       tq;

    psfd_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pressure_min (pressure_min),
        .pressure_max (pressure_max)
    );

    psfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .recip    (div_recip),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sens_in.ready = (state_reg == S_IDLE);
    assign in_acc        = sens_in.valid && sens_in.ready;
    assign slot_free     = !out_valid_reg || res_out.ready;
    assign sens_st       = sens_status_t'(sens_in.rx_byte[7:6]);

    assign mul_p = mul_a * mul_b;

    // Divide magnitudes, then restore sign: truncation toward zero
    assign prod_neg     = -prod_reg;
    assign div_dividend = prod_reg[PROD_W-1] ? prod_neg[DVD_W-1:0] : prod_reg[DVD_W-1:0];

    assign pq    = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign p_sum = 27'(pq) + 27'(pressure_min);
    assign tq    = neg_reg ? -$signed({1'b0, div_quo[13:0]}) : $signed({1'b0, div_quo[13:0]});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (sens_in.frame_start)
                    begin
                        if (sens_st == SENS_CMD || sens_st == SENS_DIAG)
                            state_next = S_EMIT;
                    end
                    else if (frame_active_reg && byte_pos_reg == 2'd3)
                        state_next = S_PMUL;
                end
            end
            S_PMUL:   state_next = S_PSTART;
            S_PSTART: state_next = S_PWAIT;
            S_PWAIT:
            begin
                if (div_done)
                    state_next = S_TMUL;
            end
            S_TMUL:   state_next = S_TOFF;
            S_TOFF:   state_next = S_TSTART;
            S_TSTART: state_next = S_TWAIT;
            S_TWAIT:
            begin
                if (div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        frame_active_next = frame_active_reg;
        byte_pos_next     = byte_pos_reg;
        p_accum_next      = p_accum_reg;
        t_high_next       = t_high_reg;
        raw_p_next        = raw_p_reg;
        raw_t_next        = raw_t_reg;
        err_next          = err_reg;
        err_code_next     = err_code_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        press_next        = press_reg;
        temp_next         = temp_reg;
        out_valid_next    = out_valid_reg && !res_out.ready;
        out_status_next   = out_status_reg;
        out_raw_p_next    = out_raw_p_reg;
        out_raw_t_next    = out_raw_t_reg;
        out_press_next    = out_press_reg;
        out_temp_next     = out_temp_reg;
        mul_a             = '0;
        mul_b             = '0;
        div_start         = 1'b0;
        div_divisor       = TEMP_SPAN;
        div_recip         = TEMP_RECIP;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (sens_in.frame_start)
                    begin
                        // any frame in progress is dropped
                        frame_active_next = 1'b0;
                        byte_pos_next     = 2'd0;
                        unique case (sens_st)
                            SENS_NORMAL:
                            begin
                                p_accum_next      = {sens_in.rx_byte[5:0], 8'h00};
                                byte_pos_next     = 2'd1;
                                frame_active_next = 1'b1;
                            end
                            SENS_CMD:
                            begin
                                err_next      = 1'b1;
                                err_code_next = RES_CMD;
                            end
                            SENS_DIAG:
                            begin
                                err_next      = 1'b1;
                                err_code_next = RES_DIAG;
                            end
                            SENS_STALE: ;
                            default: ;
                        endcase
                    end
                    else if (frame_active_reg)
                    begin
                        unique case (byte_pos_reg)
                            2'd1:
                            begin
                                p_accum_next  = {p_accum_reg[13:8], sens_in.rx_byte};
                                byte_pos_next = 2'd2;
                            end
                            2'd2:
                            begin
                                t_high_next   = sens_in.rx_byte;
                                byte_pos_next = 2'd3;
                            end
                            2'd3:
                            begin
                                raw_p_next        = p_accum_reg;
                                raw_t_next        = {t_high_reg, sens_in.rx_byte[7:5]};
                                err_next          = 1'b0;
                                frame_active_next = 1'b0;
                                byte_pos_next     = 2'd0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_PMUL:
            begin
                mul_a     = $signed({1'b0, raw_p_reg}) - OUT_CNT_MIN;
                mul_b     = MUL_BW'(pressure_max) - MUL_BW'(pressure_min);
                prod_next = mul_p[PROD_W-1:0];
            end
            S_PSTART:
            begin
                div_start   = 1'b1;
                div_divisor = OUT_CNT_SPAN;
                div_recip   = PRESS_RECIP;
                neg_next    = prod_reg[PROD_W-1];
            end
            S_PWAIT:
            begin
                if (div_done)
                begin
                    if (p_sum > PRESS_SAT_MAX)
                        press_next = PRESS_SAT_MAX[25:0];
                    else if (p_sum < PRESS_SAT_MIN)
                        press_next = PRESS_SAT_MIN[25:0];
                    else
                        press_next = p_sum[25:0];
                end
            end
            S_TMUL:
            begin
                mul_a     = $signed({4'b0000, raw_t_reg});
                mul_b     = TEMP_GAIN;
                prod_next = mul_p[PROD_W-1:0];
            end
            S_TOFF:
            begin
                prod_next = prod_reg - TEMP_OFFSET;
            end
            S_TSTART:
            begin
                div_start   = 1'b1;
                div_divisor = TEMP_SPAN;
                div_recip   = TEMP_RECIP;
                neg_next    = prod_reg[PROD_W-1];
            end
            S_TWAIT:
            begin
                if (div_done)
                    temp_next = tq;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = err_reg ? err_code_reg : RES_VALID;
                    out_raw_p_next  = err_reg ? '0 : raw_p_reg;
                    out_raw_t_next  = err_reg ? '0 : raw_t_reg;
                    out_press_next  = err_reg ? '0 : press_reg;
                    out_temp_next   = err_reg ? '0 : temp_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_active_reg <= 1'b0;
            byte_pos_reg     <= 2'd0;
            err_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_active_reg <= frame_active_next;
            byte_pos_reg     <= byte_pos_next;
            err_reg          <= err_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_accum_reg    <= p_accum_next;
        t_high_reg     <= t_high_next;
        raw_p_reg      <= raw_p_next;
        raw_t_reg      <= raw_t_next;
        err_code_reg   <= err_code_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        press_reg      <= press_next;
        temp_reg       <= temp_next;
        out_status_reg <= out_status_next;
        out_raw_p_reg  <= out_raw_p_next;
        out_raw_t_reg  <= out_raw_t_next;
        out_press_reg  <= out_press_next;
        out_temp_reg   <= out_temp_next;
    end

    assign res_out.valid             = out_valid_reg;
    assign res_out.status_code       = out_status_reg;
    assign res_out.raw_pressure      = out_raw_p_reg;
    assign res_out.raw_temperature   = out_raw_t_reg;
    assign res_out.pressure          = out_press_reg;
    assign res_out.temperature_centi = out_temp_reg;

    // divider only finishes while the sequencer is waiting on it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_PWAIT || state_reg == S_TWAIT))
        else $error("divider done outside a wait state");

    // a result leaving the sequencer lands in the output register
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded on emit");

    // a valid reading always lies within the sensor temperature span
    a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == RES_VALID)
        |-> (out_temp_reg >= -15'sd5000 && out_temp_reg <= 15'sd15000))
        else $error("temperature result out of span");

    // no input is taken while a frame is being scaled
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PWAIT || state_reg == S_TWAIT) |-> !sens_in.ready)
        else $error("input ready during scaling");

endmodule

@@ tb/sv/pressure_sensor_frame_decode_scale_test.sv @@
// Self-checking testbench for the pressure sensor frame decoder and scaler.
`timescale 1ns / 1ps

module pressure_sensor_frame_decode_scale_test;
    import psfd_pkg::*;

    localparam int    HALF_PERIOD   = 10;
    localparam int    RESET_CYCLES  = 9;
    // Fourth byte of a frame keeps the block busy while it is scaled.
    localparam int    SETTLE_CYCLES = 120;
    localparam int    IDLE_PERCENT  = 13;
    localparam longint LIMIT_NS     = 64'd30_000_000;

    // Transfer function constants, in wide signed arithmetic
    localparam longint CNT_LO     = 1638;
    localparam longint CNT_SPAN   = 13107;
    localparam longint T_GAIN     = 20000;
    localparam longint T_OFFSET   = 10235000;
    localparam longint T_SPAN     = 2047;
    localparam longint P_SAT_HI   = 33554431;
    localparam longint P_SAT_LO   = -33554432;

    // One request on the byte channel
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } sens_byte_t;

    // One decoded reading as seen on the result channel
    typedef struct packed {
        res_status_t        status;
        logic [13:0]        raw_p;
        logic [10:0]        raw_t;
        logic signed [25:0] press;
        logic signed [14:0] temp_c;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    psfd_byte_if sens_ch ();
    psfd_res_if  res_ch ();

    pressure_sensor_frame_decode_scale u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .sens_in (sens_ch),
        .res_out (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bytes waiting to be offered, and readings the decoder owes us
    sens_byte_t byte_queue[$];
    reading_t   expected_readings[$];

    // When set, neither side inserts gaps
    bit calm = 1'b0;

    int mismatches     = 0;
    int bytes_sent     = 0;
    int readings_seen  = 0;
    int status_errors  = 0;
    int range_settings = 1;

    // ------------------------------------------------------------------
    // Shadow of the decoder: configuration plus frame tracking state.
    // Initial values match the block's reset.
    // ------------------------------------------------------------------
    logic signed [23:0] cfg_pmin   = PMIN_RESET;
    logic signed [23:0] cfg_pmax   = PMAX_RESET;
    logic [1:0]         frame_pos  = 2'd0;
    logic               in_frame   = 1'b0;
    logic [13:0]        p_collect  = 14'd0;
    logic [7:0]         t_upper    = 8'd0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Decode one accepted byte; returns 1 when it completes a reading.
    function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                       output reading_t rd);
        longint rp;
        longint rt;
        longint lo;
        longint hi;
        longint p;
        longint t;
        rd = '0;
        if (fs)
        begin
            // Any frame start abandons what was being collected
            in_frame  = 1'b0;
            frame_pos = 2'd0;
            case (sens_status_t'(b[7:6]))
                SENS_STALE:
                    return 1'b0;
                SENS_CMD:
                begin
                    rd.status = RES_CMD;
                    return 1'b1;
                end
                SENS_DIAG:
                begin
                    rd.status = RES_DIAG;
                    return 1'b1;
                end
                default:
                begin
                    p_collect = {b[5:0], 8'h00};
                    frame_pos = 2'd1;
                    in_frame  = 1'b1;
                    return 1'b0;
                end
            endcase
        end
        // Stray bytes outside a frame fall on the floor
        if (!in_frame)
            return 1'b0;
        if (frame_pos == 2'd1)
        begin
            p_collect = p_collect | {6'd0, b};
            frame_pos = 2'd2;
            return 1'b0;
        end
        if (frame_pos == 2'd2)
        begin
            t_upper   = b;
            frame_pos = 2'd3;
            return 1'b0;
        end
        // Fourth byte: scale and emit
        rp = longint'(p_collect);
        rt = longint'({t_upper, b[7:5]});
        lo = longint'(cfg_pmin);
        hi = longint'(cfg_pmax);
        p  = ((rp - CNT_LO) * (hi - lo)) / CNT_SPAN + lo;
        t  = (rt * T_GAIN - T_OFFSET) / T_SPAN;
        if (p > P_SAT_HI)
            p = P_SAT_HI;
        if (p < P_SAT_LO)
            p = P_SAT_LO;
        rd.status = RES_VALID;
        rd.raw_p  = p_collect;
        rd.raw_t  = {t_upper, b[7:5]};
        rd.press  = p[25:0];
        rd.temp_c = t[14:0];
        in_frame  = 1'b0;
        frame_pos = 2'd0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string fname, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offers queued requests, predicts on each acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        sens_byte_t nxt;
        reading_t   rd;
        if (!rst_n)
        begin
            sens_ch.valid       <= 1'b0;
            sens_ch.rx_byte     <= 8'h00;
            sens_ch.frame_start <= 1'b0;
        end
        else
        begin
            if (sens_ch.valid && sens_ch.ready)
            begin
                bytes_sent++;
                if (decode_byte(sens_ch.rx_byte, sens_ch.frame_start, rd))
                    expected_readings.push_back(rd);
            end
            // Slot is free once the current request has gone (or none was up)
            if (!sens_ch.valid || sens_ch.ready)
            begin
                if (byte_queue.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    nxt = byte_queue.pop_front();
                    sens_ch.valid       <= 1'b1;
                    sens_ch.rx_byte     <= nxt.data;
                    sens_ch.frame_start <= nxt.start;
                end
                else
                    sens_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, in-order field comparison.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_readings
        reading_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("reading with none outstanding: status %0d raw_p %0d",
                           res_ch.status_code, res_ch.raw_pressure);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    readings_seen++;
                    if (want.status != RES_VALID)
                        status_errors++;
                    check_field("status_code", longint'(want.status),
                                longint'(res_ch.status_code));
                    check_field("raw_pressure", longint'(want.raw_p),
                                longint'(res_ch.raw_pressure));
                    check_field("raw_temperature", longint'(want.raw_t),
                                longint'(res_ch.raw_temperature));
                    check_field("pressure", longint'(want.press),
                                longint'(res_ch.pressure));
                    check_field("temperature_centi", longint'(want.temp_c),
                                longint'(res_ch.temperature_centi));
                end
            end
            res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic fs);
        byte_queue.push_back('{data: b, start: fs});
    endtask

    // Well-formed four byte frame; the unused low bits of byte four are noise
    task automatic push_frame(input logic [13:0] rawp, input logic [10:0] rawt);
        push_byte({SENS_NORMAL, rawp[13:8]}, 1'b1);
        push_byte(rawp[7:0], 1'b0);
        push_byte(rawt[10:3], 1'b0);
        push_byte({rawt[2:0], 5'($urandom)}, 1'b0);
    endtask

    // Mostly clean frames, plus error/stale statuses, cut-short frames and junk
    task automatic queue_traffic(input int target);
        int n;
        int pick;
        int k;
        n = 0;
        while (n < target)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
            begin
                push_frame(14'($urandom), 11'($urandom));
                n += 4;
            end
            else if (pick < 75)
            begin
                k = $urandom_range(3, 1);
                push_byte({SENS_NORMAL, 6'($urandom)}, 1'b1);
                repeat (k - 1) push_byte(8'($urandom), 1'b0);
                n += k;
            end
            else if (pick < 83)
            begin
                push_byte({($urandom_range(1) ? SENS_CMD : SENS_DIAG), 6'($urandom)}, 1'b1);
                n++;
            end
            else if (pick < 88)
            begin
                push_byte({SENS_STALE, 6'($urandom)}, 1'b1);
                n++;
            end
            else if (pick < 94)
                push_byte(8'($urandom), 1'b0);     // usually dropped, not counted
            else
            begin
                push_byte(8'($urandom), 1'b1);
                n++;
            end
        end
    endtask

    // Drain everything, then give the block time to go quiet
    task automatic settle();
        while (byte_queue.size() != 0 || sens_ch.valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input int unsigned idx, input logic signed [23:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= {{8{val[23]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PMIN: cfg_pmin = val;
            REG_PMAX: cfg_pmax = val;
            default: ;
        endcase
    endtask

    task automatic set_range(input logic signed [23:0] lo, input logic signed [23:0] hi);
        reg_write(REG_PMIN, lo);
        reg_write(REG_PMAX, hi);
        range_settings++;
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sens_ch.valid       = 1'b0;
        sens_ch.rx_byte     = 8'h00;
        sens_ch.frame_start = 1'b0;
        res_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stray byte, raw count extremes, range start
        push_byte(8'h5A, 1'b0);
        push_frame(14'd0, 11'd0);
        push_frame(14'h3FFF, 11'h7FF);
        push_frame(14'd1638, 11'd512);
        // Command mode arriving mid-frame abandons the frame
        push_byte({SENS_NORMAL, 6'h2A}, 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte({SENS_CMD, 6'h3F}, 1'b1);
        // Diagnostic fault on its own
        push_byte({SENS_DIAG, 6'h00}, 1'b1);
        // Stale mid-frame: frame dropped, following byte ignored
        push_byte({SENS_NORMAL, 6'h15}, 1'b1);
        push_byte({SENS_STALE, 6'h15}, 1'b1);
        push_byte(8'h77, 1'b0);
        // New frame start mid-frame restarts decoding
        push_byte({SENS_NORMAL, 6'h12}, 1'b1);
        push_byte(8'h34, 1'b0);
        push_frame(14'd8000, 11'd1500);
        settle();

        queue_traffic(270);
        settle();

        // Full span, with no gaps on either side
        calm = 1'b1;
        set_range(-24'sd8388608, 24'sd8388607);
        queue_traffic(300);
        settle();
        calm = 1'b0;

        // Reversed full span: falling line
        set_range(24'sd8388607, -24'sd8388608);
        queue_traffic(300);
        settle();

        // Degenerate range: constant output
        set_range(24'sd1234, 24'sd1234);
        queue_traffic(300);
        settle();

        set_range(24'($urandom), 24'($urandom));
        queue_traffic(300);
        settle();

        set_range(-24'sd100, -24'sd5000);
        queue_traffic(300);
        settle();

        $display("Covered %0d sensor bytes and %0d readings (%0d error statuses)",
                 bytes_sent, readings_seen, status_errors);
        $display("across %0d pressure range settings", range_settings);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
